[hdl/float32_to_half_rne_clamped_assert.svh]
// Assertion macros used by the converter top level.
`ifndef FLOAT32_TO_HALF_RNE_CLAMPED_ASSERT_SVH
`define FLOAT32_TO_HALF_RNE_CLAMPED_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define F2H_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define F2H_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/f2h_pkg.sv]
// Package with constants for the single-to-half converter.
`default_nettype none
package f2h_pkg;
  localparam logic [31:0] CLAMP_LIMIT_BITS = 32'h4766_499A;
  localparam logic [15:0] HALF_SAT_BITS    = 16'h7BFF;
  localparam logic [15:0] HALF_NEG_ZERO    = 16'h8000;
  localparam logic [31:0] SINGLE_NEG_ZERO  = 32'h8000_0000;
  localparam logic [7:0]  EXP_SPECIAL      = 8'hFF;
endpackage
`default_nettype wire

[hdl/f2h_convert.sv]
// Combinational single-to-half conversion with clamping and round to nearest even.
`default_nettype none
module f2h_convert (
  input  wire logic [31:0] single_bits,
  output logic      [15:0] half_bits
);
  import f2h_pkg::*;

  logic [31:0] u;
  logic [7:0]  ebits;
  logic [22:0] frac;
  logic [9:0]  trunc;
  logic [12:0] rem;
  logic        up;
  logic [10:0] m;
  logic [4:0]  hexp;
  logic [4:0]  sh;
  logic [23:0] nm;
  logic [23:0] strunc;
  logic [23:0] srem;
  logic [23:0] shalf;
  logic        sup;
  logic [15:0] pos;

  always_comb begin
    u      = (single_bits > CLAMP_LIMIT_BITS) ? CLAMP_LIMIT_BITS : single_bits;
    ebits  = u[30:23];
    frac   = u[22:0];
    trunc  = frac[22:13];
    rem    = frac[12:0];
    up     = (rem > 13'h1000) || ((rem == 13'h1000) && trunc[0]);
    m      = {1'b0, trunc} + {10'd0, up};
    // Normal range is exponent 113..142 after the clamp; 142 + carry stays below 143.
    hexp   = 5'(ebits - 8'd112) + 5'(m[10]);
    nm     = {1'b1, frac};
    sh     = 5'(8'd126 - ebits);
    strunc = nm >> sh;
    srem   = nm & ((24'd1 << sh) - 24'd1);
    shalf  = 24'd1 << (sh - 5'd1);
    sup    = (srem > shalf) || ((srem == shalf) && strunc[0]);
    if (ebits > 8'd142) begin
      pos = HALF_SAT_BITS;
    end else if (ebits >= 8'd113) begin
      pos = (hexp == 5'd31) ? HALF_SAT_BITS : {1'b0, hexp, m[9:0]};
    end else if (ebits >= 8'd102) begin
      pos = 16'(strunc + {23'd0, sup});
    end else begin
      pos = 16'd0;
    end
    if (single_bits[30:23] == EXP_SPECIAL) begin
      half_bits = 16'd0;
    end else if (single_bits[31]) begin
      half_bits = (single_bits == SINGLE_NEG_ZERO) ? HALF_NEG_ZERO : 16'd0;
    end else begin
      half_bits = pos;
    end
  end
endmodule
`default_nettype wire

[hdl/float32_to_half_rne_clamped.sv]
// Top level: registered single-to-half converter with valid/ready channels.
//
//  Channel | Signals                       | Direction
//  --------+-------------------------------+----------
//  input   | valid, ready, single_bits[31:0] | in
//  output  | half_valid, half_ready, half_bits[15:0] | out
//
// An accepted item is registered at the input, converted by one pass of
// combinational logic, and moves into the result register when that stage
// can take it; one item per cycle while the result side does not stall.
// Synchronous active-high reset clears both valid flags.
// When the result side stalls, the pipeline holds and ready falls only when
// both stages are full.
`default_nettype none
module float32_to_half_rne_clamped (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  output logic             ready,
  input  wire logic [31:0] single_bits,
  output logic             half_valid,
  input  wire logic        half_ready,
  output logic      [15:0] half_bits
);
  import f2h_pkg::*;

  logic        in_valid;
  logic [31:0] in_bits;
  logic [15:0] conv_bits;
  logic        out_advance;

  // The result stage takes a new item whenever it is empty or being drained.
  assign out_advance = !half_valid || half_ready;
  assign ready       = !in_valid || out_advance;

  f2h_convert u_convert (
    .single_bits (in_bits),
    .half_bits   (conv_bits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (ready) begin
      in_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && valid) begin
      in_bits <= single_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_valid <= 1'b0;
    end else if (out_advance) begin
      half_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && in_valid) begin
      half_bits <= conv_bits;
    end
  end

`include "float32_to_half_rne_clamped_assert.svh"

  `F2H_ASSERT_IMPL(a_ready_when_out_free, clk, rst, out_advance, ready)
  `F2H_ASSERT_NEXT(a_item_moves_out, clk, rst, in_valid && out_advance, half_valid)
  `F2H_ASSERT_NEXT(a_hold_on_stall, clk, rst, half_valid && !half_ready, half_valid && $stable(half_bits))
  `F2H_ASSERT_IMPL(a_not_ready_full, clk, rst, in_valid && half_valid && !half_ready, !ready)

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Testbench for the clamped single-to-half converter: directed, random and stall tests.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import f2h_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        ready;
  logic [31:0] single_bits = '0;
  logic        half_valid;
  logic        half_ready = 1'b0;
  logic [15:0] half_bits;

  // Percent chance per cycle that the sender idles or the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // While set, the receiver holds ready low regardless of its stall chance.
  bit          recv_hold = 1'b0;

  logic [15:0] expected_halves[$];
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  longint unsigned cycle_count = 0;

  localparam longint unsigned CYCLE_LIMIT = 200000;

  float32_to_half_rne_clamped uut (
    .clk(clk),
    .rst(rst),
    .valid(valid),
    .ready(ready),
    .single_bits(single_bits),
    .half_valid(half_valid),
    .half_ready(half_ready),
    .half_bits(half_bits)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicts the half pattern for a positive value that is already clamped.
  function automatic logic [15:0] convert_positive(logic [31:0] u);
    int          e;
    int          re;
    int unsigned sh;
    logic [22:0] frac;
    logic [23:0] nm;
    logic [23:0] trunc;
    logic [23:0] rem;
    logic [23:0] halfway;
    logic [10:0] m;
    bit          up;
    e = int'(u[30:23]) - 127;
    frac = u[22:0];
    if (e > 15) return HALF_SAT_BITS;
    if (e >= -14) begin
      trunc = frac >> 13;
      rem = frac & 23'h1FFF;
      up = (rem > 24'h1000) || (rem == 24'h1000 && trunc[0]);
      m = trunc[10:0] + up;
      re = e;
      if (m >= 11'h400) begin
        m = 0;
        re++;
      end
      if (re > 15) return HALF_SAT_BITS;
      return {re[4:0] + 5'd15, m[9:0]};
    end
    if (e >= -25) begin
      // Half subnormal: shift in the hidden bit and round to nearest even.
      nm = {1'b1, frac};
      sh = -e - 1;
      trunc = nm >> sh;
      rem = nm & ((24'd1 << sh) - 24'd1);
      halfway = 24'd1 << (sh - 1);
      up = (rem > halfway) || (rem == halfway && trunc[0]);
      return trunc[15:0] + up;
    end
    return 16'h0000;
  endfunction

  function automatic logic [15:0] predict_half(logic [31:0] u);
    if (u[30:23] == EXP_SPECIAL) return 16'h0000;
    if (u[31]) return (u == SINGLE_NEG_ZERO) ? HALF_NEG_ZERO : 16'h0000;
    if (u > CLAMP_LIMIT_BITS) u = CLAMP_LIMIT_BITS;
    return convert_positive(u);
  endfunction

  // Offers one item, idling first at random, and waits until it is accepted.
  // Valid stays high after acceptance so the next item can follow directly;
  // the idle loop or the drain drops it.
  task automatic send_single(logic [31:0] bits_in);
    while ($urandom_range(99) < send_idle_pct) begin
      valid <= 1'b0;
      @(posedge clk);
    end
    valid <= 1'b1;
    single_bits <= bits_in;
    expected_halves.push_back(predict_half(bits_in));
    items_sent++;
    @(posedge clk);
    while (!ready) @(posedge clk);
  endtask

  // Receiver: ready is redrawn at every rising edge.
  always @(posedge clk) begin
    if (rst) begin
      half_ready <= 1'b0;
    end else begin
      half_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && half_valid && half_ready) begin
      if (expected_halves.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, half_bits);
        error_count++;
      end else begin
        if (half_bits !== expected_halves[0]) begin
          $display("%0t: half_bits mismatch, expected %h, actual %h",
                   $realtime, expected_halves[0], half_bits);
          error_count++;
        end
        void'(expected_halves.pop_front());
        results_checked++;
      end
    end
  end

  // Watchdog on the total cycle count.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] make_single(bit s, logic [7:0] e, logic [22:0] f);
    return {s, e, f};
  endfunction

  // Random single with its exponent weighted toward the interesting ranges.
  function automatic logic [31:0] random_single();
    logic [7:0] e;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) e = 8'($urandom_range(142, 112));       // half normal range and the exponent just below it
    else if (pick < 60) e = 8'($urandom_range(111, 100));  // half subnormal range and the underflow edge
    else if (pick < 70) e = 8'($urandom_range(99, 95));    // flushed to zero, below the underflow edge
    else if (pick < 80) e = 8'($urandom_range(145, 140));  // near the clamp
    else if (pick < 85) e = EXP_SPECIAL;
    else if (pick < 88) e = 8'h00;
    else e = 8'($urandom);
    // Bias the fraction toward rounding ties now and then.
    if ($urandom_range(3) == 0)
      return make_single($urandom_range(9) == 0, e,
                         {10'($urandom_range(1023)), 13'h1000});
    return make_single($urandom_range(9) == 0, e, 23'($urandom));
  endfunction

  task automatic wait_drain();
    valid <= 1'b0;
    while (expected_halves.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [31:0] cases[$];
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cases = '{32'h0000_0000, SINGLE_NEG_ZERO, 32'h7F80_0000, 32'hFF80_0000,
              32'h7FC0_0001, 32'hFFFF_FFFF, 32'h8000_0001, 32'hBF80_0000,
              32'h0000_0001, 32'h007F_FFFF, 32'h3300_0000, 32'h3300_0001,
              32'h32FF_FFFF, 32'h3380_0000, 32'h3880_0000, 32'h387F_FFFF,
              32'h3F80_0000, 32'h3F80_1000, 32'h3F80_3000, 32'h3F80_1001,
              32'h3FFF_F000, CLAMP_LIMIT_BITS, CLAMP_LIMIT_BITS + 1,
              32'h7F7F_FFFF, 32'h477F_E000};
    foreach (cases[i]) send_single(cases[i]);
    wait_drain();
  endtask

  task automatic test_random_phase(int unsigned n, int unsigned idle, int unsigned stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_single(random_single());
    wait_drain();
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        recv_hold = 1'b1;
        repeat (60) @(posedge clk);
        recv_hold = 1'b0;
      end
      repeat (40) send_single(random_single());
    join
    wait_drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(400, 0, 0);
    test_random_phase(350, 71, 0);
    test_random_phase(350, 0, 71);
    test_random_phase(350, 21, 21);
    test_backpressure();
    // Random items, then full random input patterns.
    test_random_phase(50, 0, 0);
    repeat (32) send_single($urandom);
    wait_drain();
    $display("Covered %0d items: specials, signed zeros, clamp, rounding ties,", items_sent);
    $display("subnormal shifts and underflow; %0d results checked.", results_checked);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
